@@ hdl/bgs_pkg.sv @@
// ----------------------------------------------------------------------------
// bgs_pkg
// shared types and codes for the bilinear grid sampler
// ----------------------------------------------------------------------------
package bgs_pkg;

    localparam int WORD_W    = 32;
    localparam int NUM_CH    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int SIZE_W    = 9;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [CFG_IDX_W-1:0]     t_cfg_idx;

    // item function codes
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // register indexes
    localparam t_cfg_idx REG_GRID_W   = 3'd0;
    localparam t_cfg_idx REG_GRID_H   = 3'd1;
    localparam t_cfg_idx REG_ORIGIN_X = 3'd2;
    localparam t_cfg_idx REG_ORIGIN_Y = 3'd3;
    localparam t_cfg_idx REG_SCALE_X  = 3'd4;
    localparam t_cfg_idx REG_SCALE_Y  = 3'd5;

endpackage

@@ hdl/bilinear_grid_sampler_top.sv @@
// ----------------------------------------------------------------------------
// bilinear_grid_sampler_top
// four-channel grid store with pipelined bilinear sampling
// ----------------------------------------------------------------------------
// usage
//   command channel: i_start with i_func and payload; a beat is taken on any
//   edge with i_start high, o_busy is never raised, one beat per cycle
//   write beat (i_func = 0): stores one cell, no result
//   sample beat (i_func = 1): one result beat on o_sample_ch*, marked by
//   o_valid for exactly one cycle, raised once the beat has passed the
//   r_smp delay line and the output register
//   throughput: one beat per clock, writes and samples freely mixed; the
//   four channel lanes and the parity-banked memories run in lockstep, each
//   bank taking one read and one write per cycle
//   writes land at the same pipeline stage as sample reads, so every sample
//   sees exactly the cells written by earlier beats
//   config: i_cfg_we / i_cfg_idx / i_cfg_data, only while the pipe is empty
//   reset: control and config registers return to defaults (256 x 256 grid,
//   zero origin, unit scale); cell memory keeps its contents, no clear pass
//   there is no stall: results leave regardless of the receiver
// ----------------------------------------------------------------------------
module bilinear_grid_sampler_top #(
    parameter int MAX_GRID_W = 256,
    parameter int MAX_GRID_H = 256,
    parameter int FRAC_BITS  = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic                     i_func,
    input  logic [7:0]               i_cell_col,
    input  logic [7:0]               i_cell_row,
    input  bgs_pkg::t_word           i_write_ch0,
    input  bgs_pkg::t_word           i_write_ch1,
    input  bgs_pkg::t_word           i_write_ch2,
    input  bgs_pkg::t_word           i_write_ch3,
    input  bgs_pkg::t_word           i_pos_x,
    input  bgs_pkg::t_word           i_pos_y,
    input  logic                     i_cfg_we,
    input  bgs_pkg::t_cfg_idx        i_cfg_idx,
    input  logic [bgs_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output logic                     o_valid,
    output bgs_pkg::t_word           o_sample_ch0,
    output bgs_pkg::t_word           o_sample_ch1,
    output bgs_pkg::t_word           o_sample_ch2,
    output bgs_pkg::t_word           o_sample_ch3
);
    import bgs_pkg::*;

    // coordinate widths, at least two bits so the parity split has a remainder
    localparam int XB  = ($clog2(MAX_GRID_W) < 2) ? 2 : $clog2(MAX_GRID_W);
    localparam int YB  = ($clog2(MAX_GRID_H) < 2) ? 2 : $clog2(MAX_GRID_H);
    localparam int SWW = $clog2(MAX_GRID_W + 1);
    localparam int SWH = $clog2(MAX_GRID_H + 1);
    // command edge to output register load
    localparam int PIPE_LEN = 7;
    // command edge to memory access stage
    localparam int WR_LEN   = 3;

    // ---------------- configuration registers ----------------
    logic [SIZE_W-1:0] r_grid_w, r_grid_h;
    t_word             r_origin_x, r_origin_y;
    logic [31:0]       r_scale_x, r_scale_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w   <= SIZE_W'(256);
            r_grid_h   <= SIZE_W'(256);
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_scale_x  <= 32'd65536;
            r_scale_y  <= 32'd65536;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GRID_W:   r_grid_w   <= i_cfg_data[SIZE_W-1:0];
                REG_GRID_H:   r_grid_h   <= i_cfg_data[SIZE_W-1:0];
                REG_ORIGIN_X: r_origin_x <= i_cfg_data;
                REG_ORIGIN_Y: r_origin_y <= i_cfg_data;
                REG_SCALE_X:  r_scale_x  <= i_cfg_data;
                REG_SCALE_Y:  r_scale_y  <= i_cfg_data;
                default: ;  // unknown index, ignored
            endcase
        end
    end

    // sizes in use saturate at the grid maximum
    logic [SWW-1:0] size_w;
    logic [SWH-1:0] size_h;

    assign size_w = (32'(r_grid_w) > 32'(MAX_GRID_W)) ? SWW'(MAX_GRID_W) : SWW'(r_grid_w);
    assign size_h = (32'(r_grid_h) > 32'(MAX_GRID_H)) ? SWH'(MAX_GRID_H) : SWH'(r_grid_h);

    // ---------------- command decode ----------------
    logic take;
    logic take_sample;
    logic take_write;

    assign o_busy      = 1'b0;  // pipeline takes a beat every cycle
    assign take        = i_start && !o_busy;
    assign take_sample = take && (i_func == FUNC_SAMPLE);
    // cells outside the physical grid are dropped
    assign take_write  = take && (i_func == FUNC_WRITE)
                       && (32'(i_cell_col) < 32'(MAX_GRID_W))
                       && (32'(i_cell_row) < 32'(MAX_GRID_H));

    // sample tracking: valid and zero-size flag ride alongside the lanes
    logic [PIPE_LEN-1:0] r_smp;
    logic [PIPE_LEN-1:0] r_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp <= '0;
        end else begin
            r_smp <= {r_smp[PIPE_LEN-2:0], take_sample};
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero <= {r_zero[PIPE_LEN-2:0], (r_grid_w == '0) || (r_grid_h == '0)};
    end

    // write beats are delayed to the read stage so order is kept
    logic [WR_LEN-1:0] r_wen;
    logic [XB-1:0]     r_wcol [WR_LEN];
    logic [YB-1:0]     r_wrow [WR_LEN];
    t_word             r_wdat [WR_LEN][NUM_CH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wen <= '0;
        end else begin
            r_wen <= {r_wen[WR_LEN-2:0], take_write};
        end
    end

    always_ff @(posedge i_clk) begin
        r_wcol[0]    <= XB'(i_cell_col);
        r_wrow[0]    <= YB'(i_cell_row);
        r_wdat[0][0] <= i_write_ch0;
        r_wdat[0][1] <= i_write_ch1;
        r_wdat[0][2] <= i_write_ch2;
        r_wdat[0][3] <= i_write_ch3;
        for (int s = 1; s < WR_LEN; s++) begin
            r_wcol[s] <= r_wcol[s-1];
            r_wrow[s] <= r_wrow[s-1];
            r_wdat[s] <= r_wdat[s-1];
        end
    end

    // ---------------- texel coordinates, one unit per axis ----------------
    logic [XB-1:0]        x0, x1;
    logic [YB-1:0]        y0, y1;
    logic [FRAC_BITS-1:0] fx, fy;

    bgs_coord #(.XB(XB), .SW(SWW), .FB(FRAC_BITS)) u_coord_x (
        .i_clk    (i_clk),
        .i_pos    (i_pos_x),
        .i_origin (r_origin_x),
        .i_scale  (r_scale_x),
        .i_size   (size_w),
        .o_c0     (x0),
        .o_c1     (x1),
        .o_frac   (fx)
    );

    bgs_coord #(.XB(YB), .SW(SWH), .FB(FRAC_BITS)) u_coord_y (
        .i_clk    (i_clk),
        .i_pos    (i_pos_y),
        .i_origin (r_origin_y),
        .i_scale  (r_scale_y),
        .i_size   (size_h),
        .o_c0     (y0),
        .o_c1     (y1),
        .o_frac   (fy)
    );

    // ---------------- channel lanes ----------------
    t_word lane_val [NUM_CH];

    for (genvar gc = 0; gc < NUM_CH; gc++) begin : g_lane
        bgs_lane #(.XB(XB), .YB(YB), .FB(FRAC_BITS)) u_lane (
            .i_clk     (i_clk),
            .i_wr_en   (r_wen[WR_LEN-1]),
            .i_wr_col  (r_wcol[WR_LEN-1]),
            .i_wr_row  (r_wrow[WR_LEN-1]),
            .i_wr_data (r_wdat[WR_LEN-1][gc]),
            .i_x0      (x0),
            .i_x1      (x1),
            .i_fx      (fx),
            .i_y0      (y0),
            .i_y1      (y1),
            .i_fy      (fy),
            .o_value   (lane_val[gc])
        );
    end

    // ---------------- merge and output register ----------------
    // a zero grid size forces every channel to zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_smp[PIPE_LEN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_zero[PIPE_LEN-1]) begin
            o_sample_ch0 <= '0;
            o_sample_ch1 <= '0;
            o_sample_ch2 <= '0;
            o_sample_ch3 <= '0;
        end else begin
            o_sample_ch0 <= lane_val[0];
            o_sample_ch1 <= lane_val[1];
            o_sample_ch2 <= lane_val[2];
            o_sample_ch3 <= lane_val[3];
        end
    end

endmodule

@@ hdl/bgs_coord.sv @@
// ----------------------------------------------------------------------------
// bgs_coord
// world position to clamped texel corner, neighbor and fraction (3 stages)
// ----------------------------------------------------------------------------
module bgs_coord #(
    parameter int XB = 8,
    parameter int SW = 9,
    parameter int FB = 16
) (
    input  logic             i_clk,
    input  bgs_pkg::t_word   i_pos,
    input  bgs_pkg::t_word   i_origin,
    input  logic [31:0]      i_scale,
    input  logic [SW-1:0]    i_size,
    output logic [XB-1:0]    o_c0,
    output logic [XB-1:0]    o_c1,
    output logic [FB-1:0]    o_frac
);
    import bgs_pkg::*;

    logic signed [32:0] r_d;
    logic               r_pos_ok;
    logic [63:0]        r_p;
    logic [SW-1:0]      lim;
    logic [XB-1:0]      n_c0;
    logic [XB-1:0]      n_c1;
    logic [FB-1:0]      n_frac;

    // exact offset from the origin
    always_ff @(posedge i_clk) begin
        r_d <= 33'(i_pos) - 33'(i_origin);
    end

    // scale to texels, fraction of 32 bits
    always_ff @(posedge i_clk) begin
        r_pos_ok <= (r_d > 33'sd0);
        r_p      <= 64'(r_d[31:0]) * 64'(i_scale);
    end

    assign lim = i_size - SW'(1);

    always_comb begin
        if (!r_pos_ok) begin
            n_c0   = '0;
            n_frac = '0;
        end else if (r_p[63:32] >= 32'(lim)) begin
            n_c0   = XB'(lim);
            n_frac = '0;
        end else begin
            n_c0   = r_p[32 +: XB];
            n_frac = r_p[31 -: FB];
        end
        // far neighbor, held at the last column
        if (SW'(n_c0) < lim) begin
            n_c1 = n_c0 + XB'(1);
        end else begin
            n_c1 = XB'(lim);
        end
    end

    always_ff @(posedge i_clk) begin
        o_c0   <= n_c0;
        o_c1   <= n_c1;
        o_frac <= n_frac;
    end

endmodule

@@ hdl/bgs_lane.sv @@
// ----------------------------------------------------------------------------
// bgs_lane
// one channel: parity-banked cell store and two-level lerp pipeline
// ----------------------------------------------------------------------------
module bgs_lane #(
    parameter int XB = 8,
    parameter int YB = 8,
    parameter int FB = 16
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [XB-1:0]    i_wr_col,
    input  logic [YB-1:0]    i_wr_row,
    input  bgs_pkg::t_word   i_wr_data,
    input  logic [XB-1:0]    i_x0,
    input  logic [XB-1:0]    i_x1,
    input  logic [FB-1:0]    i_fx,
    input  logic [YB-1:0]    i_y0,
    input  logic [YB-1:0]    i_y1,
    input  logic [FB-1:0]    i_fy,
    output bgs_pkg::t_word   o_value
);
    import bgs_pkg::*;

    localparam int AW    = XB + YB - 2;
    localparam int DEPTH = 1 << AW;
    localparam int PW    = FB + 34;

    t_word rd_data [4];

    // four banks by row and column parity, so the four neighbors never collide
    for (genvar gb = 0; gb < 4; gb++) begin : g_bank
        localparam logic PR = 1'(gb >> 1);
        localparam logic PC = 1'(gb & 1);

        t_word         r_mem [DEPTH];
        t_word         r_rd;
        logic [XB-1:0] col_sel;
        logic [YB-1:0] row_sel;
        logic [AW-1:0] rd_addr;
        logic [AW-1:0] wr_addr;
        logic          wr_hit;

        assign col_sel = (i_x0[0] == PC) ? i_x0 : i_x1;
        assign row_sel = (i_y0[0] == PR) ? i_y0 : i_y1;
        assign rd_addr = {row_sel[YB-1:1], col_sel[XB-1:1]};
        assign wr_addr = {i_wr_row[YB-1:1], i_wr_col[XB-1:1]};
        assign wr_hit  = i_wr_en && (i_wr_row[0] == PR) && (i_wr_col[0] == PC);

        always_ff @(posedge i_clk) begin
            if (wr_hit) begin
                r_mem[wr_addr] <= i_wr_data;
            end
            r_rd <= r_mem[rd_addr];
        end

        assign rd_data[gb] = r_rd;
    end

    // stage 3: bank select bits and weights
    logic          r_x0p, r_x1p, r_y0p, r_y1p;
    logic [FB-1:0] r_fx_s3, r_fy_s3, r_fy_s4, r_fy_s5;

    always_ff @(posedge i_clk) begin
        r_x0p   <= i_x0[0];
        r_x1p   <= i_x1[0];
        r_y0p   <= i_y0[0];
        r_y1p   <= i_y1[0];
        r_fx_s3 <= i_fx;
        r_fy_s3 <= i_fy;
    end

    // stage 4: horizontal products
    t_word              c00, c10, c01, c11;
    logic signed [32:0] dx0, dx1;
    logic signed [FB:0] fxs;
    logic signed [PW-1:0] r_prod0, r_prod1;
    t_word              r_a0, r_a1;

    assign c00 = rd_data[{r_y0p, r_x0p}];
    assign c10 = rd_data[{r_y0p, r_x1p}];
    assign c01 = rd_data[{r_y1p, r_x0p}];
    assign c11 = rd_data[{r_y1p, r_x1p}];
    assign dx0 = 33'(c10) - 33'(c00);
    assign dx1 = 33'(c11) - 33'(c01);
    assign fxs = {1'b0, r_fx_s3};

    always_ff @(posedge i_clk) begin
        r_prod0 <= PW'(dx0) * PW'(fxs);
        r_prod1 <= PW'(dx1) * PW'(fxs);
        r_a0    <= c00;
        r_a1    <= c01;
        r_fy_s4 <= r_fy_s3;
    end

    // stage 5: row results, floor of the scaled difference
    logic signed [PW-1:0] sh0, sh1;
    t_word                r_r0, r_r1;

    assign sh0 = r_prod0 >>> FB;
    assign sh1 = r_prod1 >>> FB;

    always_ff @(posedge i_clk) begin
        r_r0    <= r_a0 + sh0[31:0];
        r_r1    <= r_a1 + sh1[31:0];
        r_fy_s5 <= r_fy_s4;
    end

    // stage 6: vertical product
    logic signed [32:0]   dy;
    logic signed [FB:0]   fys;
    logic signed [PW-1:0] r_prod_y;
    logic signed [PW-1:0] shy;
    t_word                r_base;

    assign dy  = 33'(r_r1) - 33'(r_r0);
    assign fys = {1'b0, r_fy_s5};

    always_ff @(posedge i_clk) begin
        r_prod_y <= PW'(dy) * PW'(fys);
        r_base   <= r_r0;
    end

    assign shy     = r_prod_y >>> FB;
    assign o_value = r_base + shy[31:0];

endmodule

@@ verif/bgs_sample_checker.sv @@
// ----------------------------------------------------------------------------
// bgs_sample_checker
// mirrors the grid and registers, predicts each sample and compares results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bgs_sample_checker #(
    parameter int MAX_GRID_W = 256,
    parameter int MAX_GRID_H = 256,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic                          i_func,
    input  logic [7:0]                    i_cell_col,
    input  logic [7:0]                    i_cell_row,
    input  bgs_pkg::t_word                i_write_ch0,
    input  bgs_pkg::t_word                i_write_ch1,
    input  bgs_pkg::t_word                i_write_ch2,
    input  bgs_pkg::t_word                i_write_ch3,
    input  bgs_pkg::t_word                i_pos_x,
    input  bgs_pkg::t_word                i_pos_y,
    input  logic                          i_cfg_we,
    input  bgs_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [bgs_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                          i_valid,
    input  bgs_pkg::t_word                i_sample_ch0,
    input  bgs_pkg::t_word                i_sample_ch1,
    input  bgs_pkg::t_word                i_sample_ch2,
    input  bgs_pkg::t_word                i_sample_ch3,
    output int                            o_pending,
    output int                            o_fail_count
);

    import bgs_pkg::*;

    typedef logic [NUM_CH-1:0][WORD_W-1:0] t_sample;

    typedef struct packed {
        logic [15:0] idx;
        logic [31:0] frac;
    } t_texel;

    // shadow of the cell store, one word per channel
    int cells [NUM_CH][MAX_GRID_W*MAX_GRID_H];

    logic [SIZE_W-1:0] grid_w;
    logic [SIZE_W-1:0] grid_h;
    t_word             org_x;
    t_word             org_y;
    logic [31:0]       scl_x;
    logic [31:0]       scl_y;

    t_sample expected_samples [$];

    // clamped texel coordinate along one axis
    function automatic t_texel texel_of(t_word pos, t_word org, logic [31:0] scl,
                                        int unsigned size);
        logic signed [32:0] d;
        logic [63:0]        p;
        t_texel             t;
        d = {pos[31], pos} - {org[31], org};
        t = '0;
        if (d > 0) begin
            p = {32'b0, d[31:0]} * {32'b0, scl};
            if (p[63:32] >= size - 1) begin
                t.idx = size - 1;
            end else begin
                t.idx  = p[47:32];
                t.frac = p[31 -: FRAC_BITS];
            end
        end
        return t;
    endfunction

    // a + floor((b - a) * f / 2^FRAC_BITS)
    function automatic longint blend(longint a, longint b, logic [31:0] f);
        longint fl;
        longint prod;
        fl   = f;
        prod = (b - a) * fl;
        return a + (prod >>> FRAC_BITS);
    endfunction

    function automatic t_sample bilinear_sample(t_word px, t_word py);
        int unsigned w;
        int unsigned h;
        int unsigned x1;
        int unsigned y1;
        t_texel      tx;
        t_texel      ty;
        longint      r0;
        longint      r1;
        longint      v;
        t_sample     s;
        w = (grid_w > MAX_GRID_W) ? MAX_GRID_W : grid_w;
        h = (grid_h > MAX_GRID_H) ? MAX_GRID_H : grid_h;
        s = '0;
        if (w != 0 && h != 0) begin
            tx = texel_of(px, org_x, scl_x, w);
            ty = texel_of(py, org_y, scl_y, h);
            x1 = (tx.idx + 1 < w) ? tx.idx + 1 : w - 1;
            y1 = (ty.idx + 1 < h) ? ty.idx + 1 : h - 1;
            for (int c = 0; c < NUM_CH; c++) begin
                r0 = blend(cells[c][ty.idx*MAX_GRID_W + tx.idx],
                           cells[c][ty.idx*MAX_GRID_W + x1], tx.frac);
                r1 = blend(cells[c][y1*MAX_GRID_W + tx.idx],
                           cells[c][y1*MAX_GRID_W + x1], tx.frac);
                v  = blend(r0, r1, ty.frac);
                s[c] = v[31:0];
            end
        end
        return s;
    endfunction

    always @(posedge i_clk) begin
        t_sample got;
        t_sample want;
        if (!i_rst_n) begin
            grid_w = 9'd256;
            grid_h = 9'd256;
            org_x  = '0;
            org_y  = '0;
            scl_x  = 32'd65536;
            scl_y  = 32'd65536;
            expected_samples.delete();
        end else begin
            // result beats leave first: they belong to beats taken earlier
            if (i_valid) begin
                got = {i_sample_ch3, i_sample_ch2, i_sample_ch1, i_sample_ch0};
                if (expected_samples.size() == 0) begin
                    $error("result beat with no sample outstanding");
                    o_fail_count++;
                end else begin
                    want = expected_samples.pop_front();
                    for (int c = 0; c < NUM_CH; c++) begin
                        if (got[c] !== want[c]) begin
                            $error("sample_ch%0d: expected %h, actual %h", c, want[c], got[c]);
                            o_fail_count++;
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_GRID_W:   grid_w = i_cfg_data[SIZE_W-1:0];
                    REG_GRID_H:   grid_h = i_cfg_data[SIZE_W-1:0];
                    REG_ORIGIN_X: org_x  = i_cfg_data;
                    REG_ORIGIN_Y: org_y  = i_cfg_data;
                    REG_SCALE_X:  scl_x  = i_cfg_data;
                    REG_SCALE_Y:  scl_y  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                if (i_func == FUNC_WRITE) begin
                    if (i_cell_col < MAX_GRID_W && i_cell_row < MAX_GRID_H) begin
                        cells[0][i_cell_row*MAX_GRID_W + i_cell_col] = i_write_ch0;
                        cells[1][i_cell_row*MAX_GRID_W + i_cell_col] = i_write_ch1;
                        cells[2][i_cell_row*MAX_GRID_W + i_cell_col] = i_write_ch2;
                        cells[3][i_cell_row*MAX_GRID_W + i_cell_col] = i_write_ch3;
                    end
                end else begin
                    expected_samples.push_back(bilinear_sample(i_pos_x, i_pos_y));
                end
            end
        end
        o_pending = expected_samples.size();
    end

endmodule

@@ verif/bilinear_grid_sampler_top_tb.sv @@
// ----------------------------------------------------------------------------
// bilinear_grid_sampler_top_tb
// drives cell writes and sample beats through the sampler under many register
// settings; a side checker predicts every sample and compares it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bilinear_grid_sampler_top_tb;

    import bgs_pkg::*;

    localparam int GRID_W          = 256;
    localparam int GRID_H          = 256;
    localparam int FRAC_W          = 16;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 170;
    // pipe is 8 deep, leave some slack before touching registers
    localparam int SETTLE_CYCLES   = 12;

    // indexes past the last register, must be ignored
    localparam t_cfg_idx REG_SPARE_LO = 3'd6;
    localparam t_cfg_idx REG_SPARE_HI = 3'd7;

    localparam t_word Q_MAX  = 32'h7FFF_FFFF;
    localparam t_word Q_MIN  = 32'h8000_0000;
    localparam t_word Q_ONE  = 32'h0001_0000;
    localparam t_word Q_HALF = 32'h0000_8000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic                 func      = FUNC_WRITE;
    logic [7:0]           cell_col  = '0;
    logic [7:0]           cell_row  = '0;
    t_word                write_ch0 = '0;
    t_word                write_ch1 = '0;
    t_word                write_ch2 = '0;
    t_word                write_ch3 = '0;
    t_word                pos_x     = '0;
    t_word                pos_y     = '0;
    logic                 cfg_we    = 1'b0;
    t_cfg_idx             cfg_idx   = REG_GRID_W;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    logic  busy;
    logic  valid;
    t_word sample_ch0;
    t_word sample_ch1;
    t_word sample_ch2;
    t_word sample_ch3;

    int pending;
    int fail_count;

    // stimulus bookkeeping
    int n_cell_writes = 0;
    int n_samples     = 0;
    int n_reg_writes  = 0;
    int burst_left    = 0;
    bit burst         = 1'b0;

    // register values written by configure, also used to aim positions
    int unsigned cur_w;
    int unsigned cur_h;
    t_word       cur_ox;
    t_word       cur_oy;
    logic [31:0] cur_sx;
    logic [31:0] cur_sy;

    always #10 clk = ~clk;

    bilinear_grid_sampler_top #(
        .MAX_GRID_W (GRID_W),
        .MAX_GRID_H (GRID_H),
        .FRAC_BITS  (FRAC_W)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .o_busy       (busy),
        .i_func       (func),
        .i_cell_col   (cell_col),
        .i_cell_row   (cell_row),
        .i_write_ch0  (write_ch0),
        .i_write_ch1  (write_ch1),
        .i_write_ch2  (write_ch2),
        .i_write_ch3  (write_ch3),
        .i_pos_x      (pos_x),
        .i_pos_y      (pos_y),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_valid      (valid),
        .o_sample_ch0 (sample_ch0),
        .o_sample_ch1 (sample_ch1),
        .o_sample_ch2 (sample_ch2),
        .o_sample_ch3 (sample_ch3)
    );

    // watches both channels and the register port, owns the prediction
    bgs_sample_checker #(
        .MAX_GRID_W (GRID_W),
        .MAX_GRID_H (GRID_H),
        .FRAC_BITS  (FRAC_W)
    ) u_sample_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_func       (func),
        .i_cell_col   (cell_col),
        .i_cell_row   (cell_row),
        .i_write_ch0  (write_ch0),
        .i_write_ch1  (write_ch1),
        .i_write_ch2  (write_ch2),
        .i_write_ch3  (write_ch3),
        .i_pos_x      (pos_x),
        .i_pos_y      (pos_y),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_valid      (valid),
        .i_sample_ch0 (sample_ch0),
        .i_sample_ch1 (sample_ch1),
        .i_sample_ch2 (sample_ch2),
        .i_sample_ch3 (sample_ch3),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // word with extra weight on the signed extremes, zero and minus one
    function automatic t_word rand_word();
        case ($urandom_range(0, 7))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // idle cycles before the next beat; runs of back-to-back beats mixed in
    function automatic int next_gap();
        if (burst_left == 0) begin
            burst      = ($urandom_range(0, 2) == 0);
            burst_left = $urandom_range(16, 160);
        end
        burst_left--;
        return burst ? 0 : $urandom_range(0, 12);
    endfunction

    // world position near or inside the grid along one axis, at times a random word
    function automatic t_word aim(t_word org, logic [31:0] scl, int unsigned size);
        longint texel;
        longint offset;
        longint sc;
        if (scl == 0 || $urandom_range(0, 5) == 0)
            return rand_word();
        sc = scl;
        case ($urandom_range(0, 7))
            // exactly on the last column or row
            0:       texel = longint'(size) * 65536 - 65536;
            // on a cell corner, zero weight
            1:       texel = longint'($urandom_range(0, size)) * 65536;
            // anywhere from one texel before to one past the end
            default: texel = longint'($urandom_range(0, (size + 2) * 65536)) - 65536;
        endcase
        offset = (texel * 65536) / sc;
        return t_word'(longint'(org) + offset);
    endfunction

    // size register data, sometimes with junk above the 9 used bits
    function automatic logic [31:0] size_data(int unsigned v);
        logic [31:0] d;
        d      = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
        d[8:0] = v[8:0];
        return d;
    endfunction

    function automatic int unsigned pick_size();
        case ($urandom_range(0, 11))
            0:       return 256;
            1:       return 1;
            2:       return 2;
            3:       return 0;
            4:       return $urandom_range(257, 511);
            default: return $urandom_range(3, 256);
        endcase
    endfunction

    function automatic logic [31:0] pick_scale();
        case ($urandom_range(0, 9))
            0:       return 32'd65536;
            1:       return 32'd0;
            2:       return 32'hFFFF_FFFF;
            3:       return $urandom;
            default: return $urandom_range(32'd4096, 32'd1048576);
        endcase
    endfunction

    function automatic t_word pick_origin();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return Q_MIN;
            2:       return Q_MAX;
            default: return t_word'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
        endcase
    endfunction

    // one command beat; start stays high when the next beat follows at once
    task automatic issue(input logic f, input logic [7:0] col, input logic [7:0] row,
                         input t_word c0, input t_word c1, input t_word c2,
                         input t_word c3, input t_word px, input t_word py);
        int gap;
        gap = next_gap();
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start     <= 1'b1;
        func      <= f;
        cell_col  <= col;
        cell_row  <= row;
        write_ch0 <= c0;
        write_ch1 <= c1;
        write_ch2 <= c2;
        write_ch3 <= c3;
        pos_x     <= px;
        pos_y     <= py;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // position fields carry noise on a cell write, they must be ignored
    task automatic put_cell(input logic [7:0] col, input logic [7:0] row, input t_word c0,
                            input t_word c1, input t_word c2, input t_word c3);
        issue(FUNC_WRITE, col, row, c0, c1, c2, c3, $urandom, $urandom);
        n_cell_writes++;
    endtask

    // and the cell fields carry noise on a sample
    task automatic put_sample(input t_word px, input t_word py);
        issue(FUNC_SAMPLE, $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom, $urandom, $urandom, $urandom, px, py);
        n_samples++;
    endtask

    // stop sending, wait for every outstanding sample, then let the pipe empty
    task automatic settle();
        int n;
        start <= 1'b0;
        @(negedge clk);
        n = 0;
        while (pending != 0 && n < 400) begin
            @(negedge clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // only called with the pipe empty
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(negedge clk);
        n_reg_writes++;
    endtask

    // register set for one phase: 0 loads reset values, 1 pins the extremes, rest random
    task automatic configure(input int ph);
        if (ph == 0) begin
            cur_w  = 256;
            cur_h  = 256;
            cur_ox = '0;
            cur_oy = '0;
            cur_sx = 32'd65536;
            cur_sy = 32'd65536;
        end else if (ph == 1) begin
            // oversized sizes saturate, far origins, widest scale
            cur_w  = 511;
            cur_h  = $urandom_range(257, 511);
            cur_ox = Q_MIN;
            cur_oy = Q_MAX;
            cur_sx = 32'hFFFF_FFFF;
            cur_sy = $urandom_range(32'd4096, 32'd1048576);
        end else begin
            cur_w  = pick_size();
            cur_h  = pick_size();
            cur_ox = pick_origin();
            cur_oy = pick_origin();
            cur_sx = pick_scale();
            cur_sy = pick_scale();
        end
        write_reg(REG_GRID_W, size_data(cur_w));
        write_reg(REG_GRID_H, size_data(cur_h));
        write_reg(REG_ORIGIN_X, cur_ox);
        write_reg(REG_ORIGIN_Y, cur_oy);
        write_reg(REG_SCALE_X, cur_sx);
        write_reg(REG_SCALE_Y, cur_sy);
        if (ph == 2) begin
            write_reg(REG_SPARE_LO, $urandom);
            write_reg(REG_SPARE_HI, $urandom);
        end
    endtask

    initial begin
        int unsigned eff_w;
        int unsigned eff_h;

        // synchronous reset, held low from the start
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed: 2x2 grid, only the four written cells can be read ----
        write_reg(REG_GRID_W, 32'd2);
        write_reg(REG_GRID_H, 32'd2);
        write_reg(REG_ORIGIN_X, '0);
        write_reg(REG_ORIGIN_Y, '0);
        write_reg(REG_SCALE_X, 32'd65536);
        write_reg(REG_SCALE_Y, 32'd65536);
        put_cell(8'd0, 8'd0, Q_MAX, Q_MIN, '0, '1);
        put_cell(8'd1, 8'd0, Q_MIN, Q_MAX, '1, '0);
        put_cell(8'd0, 8'd1, Q_MIN, '0, Q_MAX, 32'sh0001_8000);
        put_cell(8'd1, 8'd1, Q_MAX, '1, Q_MIN, 32'shFFFE_8000);
        // corner, half way with full-range differences, largest fraction
        put_sample('0, '0);
        put_sample(Q_HALF, Q_HALF);
        put_sample(32'h0000_FFFF, 32'h0000_FFFF);
        // integer part reaches size-1, then clamps at both ends
        put_sample(Q_ONE, '0);
        put_sample(Q_MIN, Q_MAX);
        put_sample(Q_MAX, Q_MIN);
        put_sample(32'h0000_4000, 32'h0000_C000);
        settle();

        // zero width, then zero height: all channels read back as zero
        write_reg(REG_GRID_W, '0);
        put_sample(Q_HALF, Q_HALF);
        settle();
        write_reg(REG_GRID_W, 32'd2);
        write_reg(REG_GRID_H, '0);
        put_sample(Q_HALF, Q_HALF);
        settle();

        // zero scale pins column 0 with a zero weight
        write_reg(REG_GRID_H, 32'd2);
        write_reg(REG_SCALE_X, '0);
        put_sample(Q_HALF, Q_HALF);
        settle();

        // widest offset and scale, then position equal to the origin
        write_reg(REG_SCALE_X, 32'hFFFF_FFFF);
        write_reg(REG_ORIGIN_X, Q_MIN);
        put_sample(Q_MAX, Q_HALF);
        settle();
        write_reg(REG_ORIGIN_X, Q_MAX);
        put_sample(Q_MIN, Q_HALF);
        put_sample(Q_MAX, Q_HALF);
        settle();

        // ---- load every cell so no later sample can touch stale memory ----
        for (int r = 0; r < GRID_H; r++)
            for (int c = 0; c < GRID_W; c++)
                put_cell(r[7:0] == 8'd0 ? c[7:0] : c[7:0], r[7:0],
                         rand_word(), rand_word(), rand_word(), rand_word());
        settle();

        // ---- random phases, each one starts from an empty pipe ----
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            configure(ph);
            eff_w = (cur_w > GRID_W) ? GRID_W : cur_w;
            eff_h = (cur_h > GRID_H) ? GRID_H : cur_h;
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if ($urandom_range(0, 3) == 0)
                    put_cell($urandom_range(0, 255), $urandom_range(0, 255),
                             rand_word(), rand_word(), rand_word(), rand_word());
                else
                    put_sample(aim(cur_ox, cur_sx, eff_w), aim(cur_oy, cur_sy, eff_h));
            end
            settle();
        end

        if (pending != 0)
            $error("%0d samples never came back", pending);

        $display("covered %0d cell writes and %0d samples, %0d register writes",
                 n_cell_writes, n_samples, n_reg_writes);
        $display("settings swept: zero, unit, oversized sizes; extreme origins and scales");
        if (fail_count == 0 && pending == 0)
            $display("bilinear_grid_sampler_top regression: pass");
        else
            $display("bilinear_grid_sampler_top regression: fail");
        $finish;
    end

    // hard stop, several times the slowest legal run
    initial begin
        #80_000_000;
        $display("bilinear_grid_sampler_top regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/bgs_pkg.sv
hdl/bgs_coord.sv
hdl/bgs_lane.sv
hdl/bilinear_grid_sampler_top.sv
verif/bgs_sample_checker.sv
verif/bilinear_grid_sampler_top_tb.sv
